>>> design/b64d_pkg.sv
// Shared types, result kinds and the character map for the base64 stream decoder.
// No dependencies; every design file but b64d_if imports this package.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_PAD  = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_SLASH = 8'd47;
  localparam logic [7:0] CHAR_PAD   = 8'd61;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] value;
  } sextet_t;

  // Up to three results from one symbol: bytes left aligned in data,
  // eom applies to the final result of the group only.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  count;
    logic [1:0]  kind;
    logic        eom;
  } group_t;

  function automatic sextet_t decode_char(input logic [7:0] c);
    sextet_t s;
    s = '0;
    case (c) inside
      [8'd65:8'd90]:  s.value = 6'(c - 8'd65);
      [8'd97:8'd122]: s.value = 6'(c - 8'd71);
      [8'd48:8'd57]:  s.value = 6'(c + 8'd4);
      CHAR_PLUS:      s.value = 6'd62;
      CHAR_SLASH:     s.value = 6'd63;
      CHAR_PAD:       s.pad   = 1'b1;
      default:        s.bad   = 1'b1;
    endcase
    return s;
  endfunction

endpackage

>>> design/b64d_if.sv
// Valid/ready channel interfaces for the symbol input and the result output.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface b64d_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, symbol, last_symbol, input ready);
  modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

interface b64d_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] kind;
  logic       end_of_message;

  modport source (output valid, data_byte, kind, end_of_message, input ready);
  modport sink   (input valid, data_byte, kind, end_of_message, output ready);
endinterface

>>> design/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: front end, group queue, back end.
// Uses b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
`timescale 1ns / 1ps

// Decodes base64 text one character per request. The symbol channel takes a
// new character every cycle while the four-entry group queue has room; the
// result channel delivers one result per cycle while results.ready is high,
// so a full group of four characters yields three results and the queue
// absorbs the burst. A group is written to the queue when the character that
// completes it is accepted, then loaded into the back end, and each of its
// results is registered at the output. Each data byte comes out as kind 0; an
// invalid character, misplaced padding or a message end without data gives
// one result of kind 2, 3 or 1. The final result of a message has
// end_of_message set, and characters after an end or an error are dropped
// until the character flagged last_symbol, which returns the decoder to its
// idle state.
module base64_stream_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  b64d_sym_if.sink   symbols,
  b64d_res_if.source results
);
  import b64d_pkg::*;

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;
  group_t push_group;
  group_t pop_group;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .symbols    (symbols),
    .push       (push),
    .push_group (push_group),
    .queue_full (queue_full)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (queue_full),
    .pop        (pop),
    .pop_group  (pop_group),
    .empty      (queue_empty)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop         (pop),
    .pop_group   (pop_group),
    .results     (results)
  );

endmodule

>>> design/b64d_front.sv
// Front end: accepts symbols, keeps the group accumulator and discard state,
// and turns each symbol into a group of results. Uses b64d_pkg and b64d_sym_if.
`timescale 1ns / 1ps

module b64d_front (
  input  logic            clk,
  input  logic            rst,
  b64d_sym_if.sink        symbols,
  output logic            push,
  output b64d_pkg::group_t push_group,
  input  logic            queue_full
);
  import b64d_pkg::*;

  logic [17:0] acc;
  logic [17:0] acc_next;
  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic        discard;
  logic        discard_next;
  logic        accept;
  logic        hit;
  logic        ended;
  sextet_t     sx;

  assign symbols.ready = !queue_full;
  assign accept        = symbols.valid && symbols.ready;
  assign sx            = decode_char(symbols.symbol);
  assign push          = accept && hit;

  always_comb begin
    acc_next     = acc;
    pos_next     = pos;
    discard_next = discard;
    push_group   = '0;
    hit          = 1'b0;
    ended        = 1'b0;

    if (discard) begin
      // drop everything up to the last symbol of the message
      if (symbols.last_symbol) begin
        acc_next     = '0;
        pos_next     = '0;
        discard_next = 1'b0;
      end
    end else begin
      if (sx.bad) begin
        hit              = 1'b1;
        push_group.count = 2'd1;
        push_group.kind  = KIND_BAD;
        push_group.eom   = 1'b1;
        ended            = 1'b1;
      end else if (sx.pad) begin
        hit            = 1'b1;
        push_group.eom = 1'b1;
        ended          = 1'b1;
        if (pos < 2'd2) begin
          push_group.count = 2'd1;
          push_group.kind  = KIND_PAD;
        end else if (pos == 2'd2) begin
          push_group.count = 2'd1;
          push_group.kind  = KIND_DATA;
          push_group.data  = {acc[11:4], 16'd0};
        end else begin
          push_group.count = 2'd2;
          push_group.kind  = KIND_DATA;
          push_group.data  = {acc[17:2], 8'd0};
        end
      end else if (pos == 2'd3) begin
        hit              = 1'b1;
        push_group.count = 2'd3;
        push_group.kind  = KIND_DATA;
        push_group.data  = {acc, sx.value};
        push_group.eom   = symbols.last_symbol;
        acc_next         = '0;
        pos_next         = '0;
        ended            = symbols.last_symbol;
      end else begin
        acc_next = {acc[11:0], sx.value};
        pos_next = pos + 2'd1;
      end

      if (symbols.last_symbol) begin
        if (!ended) begin
          hit              = 1'b1;
          push_group.count = 2'd1;
          push_group.kind  = KIND_END;
          push_group.eom   = 1'b1;
        end
        acc_next = '0;
        pos_next = '0;
      end else if (ended) begin
        discard_next = 1'b1;
        acc_next     = '0;
        pos_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pos     <= '0;
      discard <= 1'b0;
    end else if (accept) begin
      acc     <= acc_next;
      pos     <= pos_next;
      discard <= discard_next;
    end
  end

endmodule

>>> design/b64d_queue.sv
// Short queue of result groups between the front end and the back end.
// Uses b64d_pkg for the entry type and depth.
`timescale 1ns / 1ps

module b64d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::group_t push_group,
  output logic             full,
  input  logic             pop,
  output b64d_pkg::group_t pop_group,
  output logic             empty
);
  import b64d_pkg::*;

  group_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full      = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty     = fill == '0;
  assign pop_group = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> design/b64d_back.sv
// Back end: takes result groups off the queue and hands out one result per
// request through a registered output. Uses b64d_pkg and b64d_res_if.
`timescale 1ns / 1ps

module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             queue_empty,
  output logic             pop,
  input  b64d_pkg::group_t pop_group,
  b64d_res_if.source       results
);
  import b64d_pkg::*;

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_eom;
  logic       load;
  logic       emit;
  logic       cur_last;
  logic [7:0] sel_byte;

  assign load     = !out_valid || results.ready;
  assign emit     = load && cur_valid;
  assign cur_last = idx == (cur.count - 2'd1);
  assign pop      = !queue_empty && (!cur_valid || (emit && cur_last));

  always_comb begin
    case (idx)
      2'd0:    sel_byte = cur.data[23:16];
      2'd1:    sel_byte = cur.data[15:8];
      default: sel_byte = cur.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= cur_valid;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (emit) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_group;
    end
    if (emit) begin
      out_byte <= sel_byte;
      out_kind <= cur.kind;
      out_eom  <= cur.eom && cur_last;
    end
  end

  assign results.valid          = out_valid;
  assign results.data_byte      = out_byte;
  assign results.kind           = out_kind;
  assign results.end_of_message = out_eom;

endmodule

>>> design/b64d_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Uses b64d_pkg for the result kinds.
`timescale 1ns / 1ps

module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] data_byte,
  input logic [1:0] kind,
  input logic       eom
);
  import b64d_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(data_byte) && $stable(kind) && $stable(eom))
    else $error("result payload changed while stalled");

  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_DATA |-> eom)
    else $error("status result without end of message");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .data_byte (results.data_byte),
  .kind      (results.kind),
  .eom       (results.end_of_message)
);
